// ----- sv/ssiq_pkg.sv -----
package ssiq_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_QUERY  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] value;
	} item_t;

	typedef struct packed {
		logic       present;
		logic       inserted;
		logic       dropped_full;
		logic [4:0] entry_count;
	} result_t;

	// capture: latch compare flags against the broadcast key
	// shift:   commit an insert, every cell past the slot takes its neighbour's entry
	typedef struct packed {
		logic capture;
		logic shift;
	} cell_ctrl_t;

endpackage

// ----- sv/sorted_set_insert_query.sv -----
// Each item is first compared against the value in every cell at once; then the match flags
// are reduced, the row is shifted for an insert and the result goes to the output register.
// A new item is taken only once the last one has committed.
// A result left waiting in the output register holds the commit of the following item.
// Reset clears the entry count and handshake state; cell contents are not reset and are
// only looked at below the count.
module sorted_set_insert_query
	import ssiq_pkg::*;
#(
	parameter int CAPACITY = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int USED_W = $clog2(CAPACITY + 1);

	logic [USED_W-1:0]  used_q;
	logic [USED_W-1:0]  used_next;
	logic               busy_q;
	logic [1:0]         op_s1;
	logic signed [31:0] value_s1;
	logic               out_valid_q;
	result_t            out_q;

	logic               in_fire;
	logic               commit;
	logic               hit;
	logic               full;
	logic               do_insert;
	logic               do_drop;
	cell_ctrl_t         ctrl;
	result_t            res_d;

	logic signed [31:0] entry_w  [CAPACITY];
	logic               beyond_w [CAPACITY];
	logic [CAPACITY-1:0] eq_w;

	assign item_ready = !busy_q;
	assign in_fire    = item_valid && item_ready;
	assign commit     = busy_q && (!out_valid_q || result_ready);

	assign hit       = |eq_w;
	assign full      = (used_q == USED_W'(CAPACITY));
	assign do_insert = commit && (op_s1 == OP_INSERT) && !hit && !full;
	assign do_drop   = (op_s1 == OP_INSERT) && !hit && full;

	assign ctrl.capture = in_fire;
	assign ctrl.shift   = do_insert;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] prev_entry;
		logic               prev_beyond;
		if (i == 0) begin : g_head
			assign prev_entry  = '0;
			assign prev_beyond = 1'b0;
		end else begin : g_link
			assign prev_entry  = entry_w[i-1];
			assign prev_beyond = beyond_w[i-1];
		end

		ssiq_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.key         (item.value),
			.ins_value   (value_s1),
			.valid       (used_q > USED_W'(i)),
			.prev_entry  (prev_entry),
			.prev_beyond (prev_beyond),
			.entry       (entry_w[i]),
			.eq          (eq_w[i]),
			.beyond      (beyond_w[i])
		);
	end

	always_comb begin
		used_next          = used_q;
		res_d.present      = 1'b0;
		res_d.inserted     = 1'b0;
		res_d.dropped_full = 1'b0;
		unique case (op_s1)
			OP_INSERT: begin
				res_d.present      = hit;
				res_d.dropped_full = do_drop;
				res_d.inserted     = !hit && !full;
				if (!hit && !full) begin
					used_next = used_q + 1'b1;
				end
			end
			OP_QUERY: begin
				res_d.present = hit;
			end
			OP_CLEAR: begin
				used_next = '0;
			end
			default: begin
			end
		endcase
		res_d.entry_count = 5'(used_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			if (commit) begin
				used_q      <= used_next;
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1    <= item.op;
			value_s1 <= item.value;
		end
		if (commit) begin
			out_q <= res_d;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |=> used_q == $past(used_q) + 1'b1)
		else $error("insert did not advance entry count");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && do_drop) |-> used_q == USED_W'(CAPACITY))
		else $error("insert dropped with room left");

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.inserted && (result.present || result.dropped_full)))
		else $error("inserted flagged together with present or dropped");

	a_commit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && out_valid_q && !result_ready) |=> busy_q && $stable(used_q))
		else $error("commit went ahead while result was waiting");

endmodule

// ----- sv/ssiq_cell.sv -----
module ssiq_cell
	import ssiq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctrl_t         ctrl,
	input  logic signed [31:0] key,
	input  logic signed [31:0] ins_value,
	input  logic               valid,
	input  logic signed [31:0] prev_entry,
	input  logic               prev_beyond,
	output logic signed [31:0] entry,
	output logic               eq,
	output logic               beyond
);

	logic signed [31:0] entry_q;
	logic               eq_s1;
	logic               beyond_s1;

	// an empty cell counts as lying past the insertion point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eq_s1     <= 1'b0;
			beyond_s1 <= 1'b0;
		end else if (ctrl.capture) begin
			eq_s1     <= valid && (entry_q == key);
			beyond_s1 <= !valid || (entry_q > key);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift && beyond_s1) begin
			entry_q <= prev_beyond ? prev_entry : ins_value;
		end
	end

	assign entry  = entry_q;
	assign eq     = eq_s1;
	assign beyond = beyond_s1;

endmodule

// ----- tb/tb_sorted_set_insert_query.sv -----
module tb_sorted_set_insert_query;
	import ssiq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SET_CAPACITY = 16;
	localparam int RANDOM_ITEMS = 1875;
	localparam int CALM_FIRST = 700;
	localparam int CALM_LAST = 999;
	localparam int IDLE_PERCENT = 22;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [1:0] OP_RESERVED = 2'd3;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} dir_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	// shadow copy of the set, ascending, valid below set_count
	logic signed [31:0] set_vals [SET_CAPACITY];
	int                 set_count = 0;
	result_t            predicted_results [$];
	int                 fail_count = 0;
	bit                 calm = 1'b0;

	// rows with typed set are checked against the typed res, others against the predictor
	dir_row_t directed_rows [25] = '{
		'{'{OP_QUERY,    32'h0000_0000}, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0}},
		'{'{OP_INSERT,   32'h7FFF_FFFF}, 1'b1, '{1'b0, 1'b1, 1'b0, 5'd1}},
		'{'{OP_INSERT,   32'h8000_0000}, 1'b1, '{1'b0, 1'b1, 1'b0, 5'd2}},
		'{'{OP_INSERT,   32'h8000_0000}, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd2}},
		'{'{OP_QUERY,    32'h7FFF_FFFF}, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd2}},
		'{'{OP_RESERVED, 32'h7FFF_FFFF}, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd2}},
		'{'{OP_INSERT,   32'hFFFF_FFFF}, 1'b0, '0},
		'{'{OP_INSERT,   32'h0000_0000}, 1'b0, '0},
		'{'{OP_INSERT,   32'h0000_0001}, 1'b0, '0},
		'{'{OP_INSERT,   32'h5555_5555}, 1'b0, '0},
		'{'{OP_INSERT,   32'hAAAA_AAAA}, 1'b0, '0},
		'{'{OP_INSERT,   32'hFFFF_FFFE}, 1'b0, '0},
		'{'{OP_INSERT,   32'h0000_0002}, 1'b0, '0},
		'{'{OP_INSERT,   32'h7FFF_FFFE}, 1'b0, '0},
		'{'{OP_INSERT,   32'h8000_0001}, 1'b0, '0},
		'{'{OP_INSERT,   32'h0000_0064}, 1'b0, '0},
		'{'{OP_INSERT,   32'hFFFF_FF9C}, 1'b0, '0},
		'{'{OP_INSERT,   32'h4000_0000}, 1'b0, '0},
		'{'{OP_INSERT,   32'hC000_0000}, 1'b0, '0},
		'{'{OP_INSERT,   32'h0000_0007}, 1'b0, '0},
		'{'{OP_INSERT,   32'h0000_0005}, 1'b1, '{1'b0, 1'b0, 1'b1, 5'd16}},
		'{'{OP_INSERT,   32'h0000_0000}, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd16}},
		'{'{OP_QUERY,    32'h8000_0000}, 1'b1, '{1'b1, 1'b0, 1'b0, 5'd16}},
		'{'{OP_CLEAR,    32'h1234_5678}, 1'b1, '{1'b0, 1'b0, 1'b0, 5'd0}},
		'{'{OP_INSERT,   32'h8000_0000}, 1'b1, '{1'b0, 1'b1, 1'b0, 5'd1}}
	};

	sorted_set_insert_query #(
		.CAPACITY(SET_CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5ms;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic result_t apply_set_op(item_t it);
		result_t r;
		int      pos;
		int      i;
		bit      hit;
		r = '0;
		hit = 1'b0;
		pos = set_count;
		if (it.op == OP_INSERT || it.op == OP_QUERY) begin
			for (i = 0; i < set_count; i++) begin
				if (set_vals[i] == it.value) begin
					hit = 1'b1;
					pos = i;
					break;
				end
				if (set_vals[i] > it.value) begin
					pos = i;
					break;
				end
			end
			r.present = hit;
			if (it.op == OP_INSERT && !hit) begin
				if (set_count >= SET_CAPACITY) begin
					r.dropped_full = 1'b1;
				end else begin
					for (i = set_count; i > pos; i--)
						set_vals[i] = set_vals[i - 1];
					set_vals[pos] = it.value;
					set_count++;
					r.inserted = 1'b1;
				end
			end
		end else if (it.op == OP_CLEAR) begin
			set_count = 0;
		end
		r.entry_count = set_count[4:0];
		return r;
	endfunction

	// mostly inserts and lookups, many on current members; clears rare enough to fill the set
	function automatic item_t random_item();
		item_t it;
		int    pick;
		int    near;
		pick = $urandom_range(999);
		if (pick < 15)
			it.op = OP_CLEAR;
		else if (pick < 40)
			it.op = OP_RESERVED;
		else if (pick < 540)
			it.op = OP_INSERT;
		else
			it.op = OP_QUERY;
		pick = $urandom_range(99);
		if (pick < 35 && set_count > 0) begin
			it.value = set_vals[$urandom_range(set_count - 1)];
		end else if (pick < 50) begin
			near = int'($urandom_range(16)) - 8;
			it.value = near;
		end else if (pick < 58) begin
			case ($urandom_range(3))
				0: it.value = 32'h7FFF_FFFF;
				1: it.value = 32'h8000_0000;
				2: it.value = 32'h0000_0000;
				default: it.value = 32'hFFFF_FFFF;
			endcase
		end else begin
			it.value = $urandom;
		end
		return it;
	endfunction

	task automatic idle_gap();
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_item(item_t it, bit typed, result_t typed_res);
		result_t p;
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		p = apply_set_op(it);
		predicted_results.insert(predicted_results.size(), typed ? typed_res : p);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		do @(posedge clk); while (predicted_results.size() != 0);
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (predicted_results.size() == 0) begin
			$error("unexpected result transaction %p", got);
			fail_count++;
		end else begin
			want = predicted_results.pop_front();
			if (got.present !== want.present) begin
				$error("present: expected %0b, got %0b", want.present, got.present);
				fail_count++;
			end
			if (got.inserted !== want.inserted) begin
				$error("inserted: expected %0b, got %0b", want.inserted, got.inserted);
				fail_count++;
			end
			if (got.dropped_full !== want.dropped_full) begin
				$error("dropped_full: expected %0b, got %0b", want.dropped_full,
					got.dropped_full);
				fail_count++;
			end
			if (got.entry_count !== want.entry_count) begin
				$error("entry_count: expected %0d, got %0d", want.entry_count,
					got.entry_count);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			check_result(result);
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
	end

	initial begin
		item_valid <= 1'b0;
		item <= '0;
		do @(posedge clk); while (!arst_n);
		@(posedge clk);

		foreach (directed_rows[i]) begin
			idle_gap();
			send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
		end
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= CALM_FIRST && n <= CALM_LAST);
			// hold off once mid-run until the block has emptied
			if (n == RANDOM_ITEMS / 2)
				drain();
			else
				idle_gap();
			send_item(random_item(), 1'b0, '0);
		end
		calm = 1'b0;

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- sorted_set_insert_query.f -----
sv/ssiq_pkg.sv
sv/ssiq_cell.sv
sv/sorted_set_insert_query.sv
tb/tb_sorted_set_insert_query.sv
